// File: rtl/mono_bitmap_blit_unit_assert.svh
// Assertion macros used by the checker module mbb_checker.
`ifndef MONO_BITMAP_BLIT_UNIT_ASSERT_SVH
`define MONO_BITMAP_BLIT_UNIT_ASSERT_SVH

// Same-edge implication, disabled while reset is asserted.
`define MBB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-edge implication, disabled while reset is asserted.
`define MBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_pkg
// Shared constants, opcodes and the command type of the bitmap blit unit.
// ----------------------------------------------------------------------------
package mbb_pkg;

  localparam int unsigned FRAME_BYTES  = 2048;
  localparam int unsigned FB_AW        = $clog2(FRAME_BYTES);
  // command address holds a 16-bit row base plus a byte offset
  localparam int unsigned CMD_AW       = 17;
  localparam logic [5:0]  STRIDE_RESET = 6'd16;

  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic {
    CMD_READ,
    CMD_MERGE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CMD_AW-1:0] addr;
    logic [7:0]        bits;
    logic              erase;
  } cmd_t;

endpackage

// File: rtl/mbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module mbb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_ctrl
// Blit sequencer: decodes input transactions, tracks row position and carry,
// and issues merge and read commands to the framebuffer pipeline.
// ----------------------------------------------------------------------------
module mbb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    operation_i,
  input  logic [7:0]    pos_x_i,
  input  logic [7:0]    pos_y_i,
  input  logic [7:0]    width_pixels_i,
  input  logic [7:0]    height_lines_i,
  input  logic          erase_mode_i,
  input  logic [7:0]    data_byte_i,
  input  logic [10:0]   read_address_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [5:0]    cfg_data_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output mbb_pkg::cmd_t cmd_o
);
  import mbb_pkg::*;

  logic [5:0]  stride_q, stride_d;
  logic [7:0]  carry_q, carry_d;
  logic [2:0]  shift_q, shift_d;
  logic [15:0] row_base_q, row_base_d;
  logic [5:0]  byte_idx_q, byte_idx_d;
  logic [5:0]  row_bytes_q, row_bytes_d;
  logic [7:0]  lines_q, lines_d;
  logic [3:0]  last_bits_q, last_bits_d;
  logic        mode_q, mode_d;
  logic        active_q, active_d;
  logic        trail_valid_q, trail_valid_d;
  cmd_t        trail_q, trail_d;

  logic              accept;
  logic [7:0]        spill_old;
  logic [7:0]        spill_new;
  logic [5:0]        idx_next;
  logic              row_end;
  logic              do_trail;
  logic [CMD_AW-1:0] merge_addr;
  logic [CMD_AW-1:0] trail_addr;
  logic [13:0]       prod;
  logic [5:0]        row_bytes_new;
  cmd_t              merge_cmd;
  cmd_t              read_cmd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !trail_valid_q && cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign spill_old  = 8'({carry_q, 8'h00} >> shift_q);
  assign spill_new  = 8'({data_byte_i, 8'h00} >> shift_q);
  assign idx_next   = byte_idx_q + 6'd1;
  assign row_end    = idx_next >= row_bytes_q;
  assign do_trail   = !mode_q || ((4'(shift_q) + last_bits_q) > 4'd8);
  assign merge_addr = CMD_AW'(row_base_q) + CMD_AW'(byte_idx_q);
  assign trail_addr = CMD_AW'(row_base_q) + CMD_AW'(idx_next);
  assign prod       = 14'(pos_y_i) * 14'(stride_q);
  assign row_bytes_new = 6'(width_pixels_i[7:3]) + 6'(width_pixels_i[2:0] != 3'd0);

  always_comb begin
    merge_cmd.kind  = CMD_MERGE;
    merge_cmd.addr  = merge_addr;
    merge_cmd.bits  = (data_byte_i >> shift_q) |
                      ((byte_idx_q != 6'd0) ? spill_old : 8'h00);
    merge_cmd.erase = mode_q;

    read_cmd.kind  = CMD_READ;
    read_cmd.addr  = CMD_AW'(read_address_i);
    read_cmd.bits  = 8'h00;
    read_cmd.erase = 1'b0;
  end

  // Command mux: a pending trailing merge goes before any new transaction.
  always_comb begin
    if (trail_valid_q) begin
      cmd_valid_o = 1'b1;
      cmd_o       = trail_q;
    end else begin
      cmd_valid_o = in_valid_i &&
                    ((operation_i == OP_READ) || ((operation_i == OP_DATA) && active_q));
      cmd_o       = (operation_i == OP_READ) ? read_cmd : merge_cmd;
    end
  end

  always_comb begin
    stride_d      = stride_q;
    carry_d       = carry_q;
    shift_d       = shift_q;
    row_base_d    = row_base_q;
    byte_idx_d    = byte_idx_q;
    row_bytes_d   = row_bytes_q;
    lines_d       = lines_q;
    last_bits_d   = last_bits_q;
    mode_d        = mode_q;
    active_d      = active_q;
    trail_valid_d = trail_valid_q;
    trail_d       = trail_q;

    if (cfg_valid_i) begin
      stride_d = cfg_data_i;
    end

    if (trail_valid_q && cmd_ready_i) begin
      trail_valid_d = 1'b0;
    end

    if (accept) begin
      unique case (operation_i)
        OP_BEGIN: begin
          shift_d     = pos_x_i[2:0];
          row_base_d  = 16'(prod) + 16'(pos_x_i[7:3]);
          last_bits_d = (width_pixels_i[2:0] != 3'd0) ? 4'(width_pixels_i[2:0]) : 4'd8;
          row_bytes_d = row_bytes_new;
          lines_d     = height_lines_i;
          mode_d      = erase_mode_i;
          byte_idx_d  = 6'd0;
          carry_d     = 8'h00;
          active_d    = (height_lines_i != 8'd0) && (row_bytes_new != 6'd0);
        end
        OP_DATA: begin
          if (active_q) begin
            carry_d    = data_byte_i;
            byte_idx_d = idx_next;
            if (row_end) begin
              // queue the trailing partial byte, step to the next line
              trail_valid_d = do_trail;
              trail_d.kind  = CMD_MERGE;
              trail_d.addr  = trail_addr;
              trail_d.bits  = spill_new;
              trail_d.erase = mode_q;
              row_base_d    = row_base_q + 16'(stride_q);
              byte_idx_d    = 6'd0;
              lines_d       = lines_q - 8'd1;
              if (lines_q == 8'd1) begin
                active_d = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q      <= STRIDE_RESET;
      carry_q       <= 8'h00;
      shift_q       <= 3'd0;
      row_base_q    <= 16'd0;
      byte_idx_q    <= 6'd0;
      row_bytes_q   <= 6'd0;
      lines_q       <= 8'd0;
      last_bits_q   <= 4'd8;
      mode_q        <= 1'b0;
      active_q      <= 1'b0;
      trail_valid_q <= 1'b0;
    end else begin
      stride_q      <= stride_d;
      carry_q       <= carry_d;
      shift_q       <= shift_d;
      row_base_q    <= row_base_d;
      byte_idx_q    <= byte_idx_d;
      row_bytes_q   <= row_bytes_d;
      lines_q       <= lines_d;
      last_bits_q   <= last_bits_d;
      mode_q        <= mode_d;
      active_q      <= active_d;
      trail_valid_q <= trail_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trail_q <= trail_d;
  end

endmodule

// File: rtl/mbb_rmw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_rmw
// Framebuffer pipeline: read in the issue cycle, merge and write back in the
// next cycle, with last-write forwarding, reset clearing pass and result
// register.
// ----------------------------------------------------------------------------
module mbb_rmw (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  mbb_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    read_data_o
);
  import mbb_pkg::*;

  logic             clearing_q, clearing_d;
  logic [FB_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic             b_valid_q, b_valid_d;
  cmd_t             b_cmd_q, b_cmd_d;
  logic             b_inrange_q, b_inrange_d;
  logic             lw_valid_q, lw_valid_d;
  logic [FB_AW-1:0] lw_addr_q, lw_addr_d;
  logic [7:0]       lw_data_q, lw_data_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_data_q, out_data_d;

  logic             re;
  logic             we;
  logic [FB_AW-1:0] waddr;
  logic [7:0]       wdata;
  logic [7:0]       rdata;
  logic [7:0]       cur;
  logic [7:0]       merged;
  logic             b_is_read;
  logic             b_stall;
  logic             b_free;
  logic             out_load;

  mbb_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (cmd_i.addr[FB_AW-1:0]),
    .rdata_o (rdata)
  );

  assign b_is_read   = b_valid_q && (b_cmd_q.kind == CMD_READ);
  assign b_stall     = b_is_read && out_valid_q && !out_ready_i;
  assign b_free      = !b_valid_q || !b_stall;
  assign cmd_ready_o = !clearing_q && b_free;
  assign re          = cmd_valid_i && cmd_ready_o;
  assign out_load    = b_is_read && !b_stall;

  // RAM is read-first: take the last written byte when it hits the same entry
  assign cur = (lw_valid_q && (lw_addr_q == b_cmd_q.addr[FB_AW-1:0])) ? lw_data_q : rdata;
  assign merged = b_cmd_q.erase ? (cur & ~b_cmd_q.bits) : (cur | b_cmd_q.bits);

  always_comb begin
    if (clearing_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = 8'h00;
    end else begin
      we    = b_valid_q && (b_cmd_q.kind == CMD_MERGE) && b_inrange_q;
      waddr = b_cmd_q.addr[FB_AW-1:0];
      wdata = merged;
    end
  end

  always_comb begin
    clearing_d  = clearing_q;
    clr_cnt_d   = clr_cnt_q;
    b_valid_d   = b_valid_q;
    b_cmd_d     = b_cmd_q;
    b_inrange_d = b_inrange_q;
    lw_valid_d  = lw_valid_q;
    lw_addr_d   = lw_addr_q;
    lw_data_d   = lw_data_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + FB_AW'(1);
      if (clr_cnt_q == FB_AW'(FRAME_BYTES - 1)) begin
        clearing_d = 1'b0;
      end
    end

    if (b_free) begin
      b_valid_d   = re;
      b_cmd_d     = cmd_i;
      b_inrange_d = cmd_i.addr < CMD_AW'(FRAME_BYTES);
    end

    if (we) begin
      lw_valid_d = 1'b1;
      lw_addr_d  = waddr;
      lw_data_d  = wdata;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = b_inrange_q ? cur : 8'h00;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      b_valid_q   <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      b_valid_q   <= b_valid_d;
      lw_valid_q  <= lw_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_cmd_q     <= b_cmd_d;
    b_inrange_q <= b_inrange_d;
    lw_addr_q   <= lw_addr_d;
    lw_data_q   <= lw_data_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule

// File: rtl/mono_bitmap_blit_unit.sv
`timescale 1ns / 1ps
// Read transaction: the result passes the registered RAM read and the result register.
// Throughput: one transaction per cycle; a data byte that ends a bitmap row
// holds the input when it issues the trailing merge, and a held
// result closes the input once a second read waits behind it.
// Reset: the framebuffer is zeroed by a clearing pass over all FRAME_BYTES entries
// (2048), during which no input transaction is accepted; config is always taken.
// ----------------------------------------------------------------------------
// mono_bitmap_blit_unit
// 1-bpp bitmap blit into a byte-wide monochrome framebuffer (OR / AND-NOT).
// ----------------------------------------------------------------------------
module mono_bitmap_blit_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [7:0]  width_pixels_i,
  input  logic [7:0]  height_lines_i,
  input  logic        erase_mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [10:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i
);
  import mbb_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  mbb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .width_pixels_i (width_pixels_i),
    .height_lines_i (height_lines_i),
    .erase_mode_i   (erase_mode_i),
    .data_byte_i    (data_byte_i),
    .read_address_i (read_address_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  mbb_rmw u_rmw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_data_o (read_data_o)
  );

endmodule

// File: rtl/mbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbb_checker
// Port-level checks of the blit unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mono_bitmap_blit_unit_assert.svh"

module mbb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  operation_i,
  input logic [7:0]  pos_x_i,
  input logic [7:0]  pos_y_i,
  input logic [7:0]  width_pixels_i,
  input logic [7:0]  height_lines_i,
  input logic        erase_mode_i,
  input logic [7:0]  data_byte_i,
  input logic [10:0] read_address_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [5:0]  cfg_data_i
);
  import mbb_pkg::*;

  // a stalled result transaction holds its data
  `MBB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(read_data_o), "result dropped or changed while stalled")

  // the clearing pass keeps the input closed right after reset
  `MBB_ASSERT_IMPLY(a_clear_closed, clk_i, rst_ni, $rose(rst_ni), !in_ready_o, "input open during clearing pass")

  // a fresh result comes only from an accepted read, through the RAM read and result registers
  `MBB_ASSERT_IMPLY(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && in_ready_o && (operation_i == OP_READ), 2), "result without a read transaction")

endmodule

bind mono_bitmap_blit_unit mbb_checker u_mbb_checker (.*);

// File: sim/tb_mono_bitmap_blit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_bitmap_blit_unit
// Drives begin, bitmap data and read transactions into the blit unit and
// keeps a shadow framebuffer with its own blit state. Every read result is
// compared with the shadow byte that was current when the read was accepted.
// Covers the zero-size, idle-data, abandoned-blit, unused-opcode and
// out-of-store cases, both merge modes, several row strides, random idling
// on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_mono_bitmap_blit_unit;
  import mbb_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned SETTLE_CYC  = 10;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned STALL_LIMIT = 6000;

  typedef struct {
    logic [10:0] addr;
    logic [7:0]  data;
  } fb_read_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_READ;
  logic [7:0]  pos_x_i = '0;
  logic [7:0]  pos_y_i = '0;
  logic [7:0]  width_pixels_i = '0;
  logic [7:0]  height_lines_i = '0;
  logic        erase_mode_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic [10:0] read_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  read_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i = '0;

  // shadow framebuffer and blit state
  logic [7:0]  fb_shadow [FRAME_BYTES];
  logic [5:0]  stride_cfg = STRIDE_RESET;
  logic [7:0]  carry_byte = '0;
  logic [2:0]  shift_amt = '0;
  logic [15:0] row_addr = '0;
  logic [5:0]  col_idx = '0;
  logic [5:0]  row_bytes = '0;
  logic [7:0]  rows_left = '0;
  logic [3:0]  tail_bits = 4'd8;
  logic        erase_on = 1'b0;
  logic        blit_busy = 1'b0;

  fb_read_t    fb_expect_q[$];
  fb_read_t    rd_exp;
  int unsigned error_count = 0;
  int unsigned items_done = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  logic        no_gaps = 1'b0;

  mono_bitmap_blit_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .width_pixels_i (width_pixels_i),
    .height_lines_i (height_lines_i),
    .erase_mode_i   (erase_mode_i),
    .data_byte_i    (data_byte_i),
    .read_address_i (read_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // bits that the carried byte pushes into the next framebuffer byte
  function automatic logic [7:0] spill_bits();
    logic [15:0] wide;
    if (shift_amt == 3'd0) return 8'h00;
    wide = {8'h00, carry_byte} << (4'd8 - {1'b0, shift_amt});
    return wide[7:0];
  endfunction

  function automatic void fb_merge(input int unsigned addr, input logic [7:0] bits);
    if (addr >= FRAME_BYTES) return;
    if (erase_on) fb_shadow[addr] = fb_shadow[addr] & ~bits;
    else fb_shadow[addr] = fb_shadow[addr] | bits;
  endfunction

  // Advance the shadow state by one accepted transaction; returns 0 when the
  // block just ignores it.
  function automatic bit blit_predict(input logic [1:0] op, input logic [7:0] x,
                                      input logic [7:0] y, input logic [7:0] w,
                                      input logic [7:0] h, input logic erase,
                                      input logic [7:0] d, input logic [10:0] raddr);
    int unsigned addr;
    logic [7:0]  bits;
    blit_predict = 1'b1;
    case (op)
      OP_BEGIN: begin
        shift_amt = x[2:0];
        row_addr  = 16'(int'(y) * int'(stride_cfg) + int'(x >> 3));
        if (w[2:0] != 3'd0) begin
          tail_bits = {1'b0, w[2:0]};
          row_bytes = 6'(int'(w >> 3) + 1);
        end else begin
          tail_bits = 4'd8;
          row_bytes = 6'(w >> 3);
        end
        rows_left  = h;
        erase_on   = erase;
        col_idx    = '0;
        carry_byte = '0;
        blit_busy  = (h != 0) && (row_bytes != 0);
      end
      OP_DATA: begin
        if (!blit_busy) return 1'b0;
        addr = int'(row_addr) + int'(col_idx);
        bits = d >> shift_amt;
        if (col_idx != 0) bits = bits | spill_bits();
        fb_merge(addr, bits);
        carry_byte = d;
        col_idx = col_idx + 6'd1;
        if (col_idx >= row_bytes) begin
          addr = int'(row_addr) + int'(col_idx);
          // erase skips the trailing byte unless the row really spills into it
          if (!erase_on || int'(shift_amt) + int'(tail_bits) > 8) fb_merge(addr, spill_bits());
          row_addr  = row_addr + 16'(stride_cfg);
          col_idx   = '0;
          rows_left = rows_left - 8'd1;
          if (rows_left == 0) blit_busy = 1'b0;
        end
      end
      OP_READ: begin
        fb_expect_q.push_back('{raddr, fb_shadow[raddr]});
      end
      default: blit_predict = 1'b0;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] w, input logic [7:0] h, input logic erase,
                           input logic [7:0] d, input logic [10:0] raddr);
    if (!no_gaps && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    pos_x_i        <= x;
    pos_y_i        <= y;
    width_pixels_i <= w;
    height_lines_i <= h;
    erase_mode_i   <= erase;
    data_byte_i    <= d;
    read_address_i <= raddr;
    do @(posedge clk_i); while (!in_ready_o);
    if (blit_predict(op, x, y, w, h, erase, d, raddr)) items_done++;
  endtask

  // unused fields carry random values so their bits toggle too
  task automatic send_begin(input int unsigned x, input int unsigned y, input int unsigned w,
                            input int unsigned h, input logic erase);
    send_item(OP_BEGIN, 8'(x), 8'(y), 8'(w), 8'(h), erase, 8'($urandom),
              11'($urandom));
  endtask

  task automatic send_data(input int unsigned d);
    send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 8'(d), 11'($urandom));
  endtask

  task automatic send_read(input int unsigned addr);
    send_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              1'($urandom), 8'($urandom), 11'(addr));
  endtask

  // wait for every pending read, then let the last merge settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (fb_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_stride(input logic [5:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    stride_cfg = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_after_reset();
    send_read(0);
    send_read(FRAME_BYTES - 1);
    send_read(1000);
    send_item(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 11'h7FF);
    send_data(8'hFF);           // idle: dropped
    send_begin(8, 0, 0, 3, 0);  // zero width stays idle
    send_begin(8, 0, 8, 0, 0);  // zero height stays idle
    send_data(8'hFF);
    send_read(1);
  endtask

  task automatic test_directed_blits();
    // aligned overlay, full byte
    send_begin(0, 0, 8, 1, 1'b0);
    send_data(8'hFF);
    send_read(0);
    send_read(1);
    // worst shift, two rows of two bytes
    send_begin(7, 1, 16, 2, 1'b0);
    repeat (4) send_data($urandom_range(255));
    send_read(16);
    send_read(18);
    send_read(34);
    // erase whose last bits end inside the byte: no trailing merge
    send_begin(3, 0, 5, 1, 1'b1);
    send_data(8'hF8);
    send_read(0);
    // erase that spills into the next byte
    send_begin(5, 0, 5, 1, 1'b1);
    send_data(8'hF8);
    send_read(1);
    // abandon a running blit, then write past the end of the store
    send_begin(2, 3, 24, 3, 1'b0);
    send_data(8'h5A);
    send_begin(255, 255, 255, 255, 1'b0);
    repeat (3) send_data(8'hFF);
    send_read(48);
  endtask

  task automatic test_random_blits(input logic [5:0] new_stride, input int unsigned n_items);
    int unsigned target, x, y, w, h, max_y, rb, nbytes, base, span;
    logic        erase;
    set_stride(new_stride);
    target = items_done + n_items;
    while (items_done < target) begin
      if ($urandom_range(99) < 75) begin
        x = $urandom_range(255);
        w = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 40);
        case ($urandom_range(19))
          0:       h = 0;
          1:       h = $urandom_range(255);
          default: h = $urandom_range(1, 4);
        endcase
        max_y = FRAME_BYTES / new_stride - 1;
        if (max_y > 255) max_y = 255;
        y = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(0, max_y);
        erase = ($urandom_range(99) < 40);
        send_begin(x, y, w, h, erase);
        rb = (w + 7) / 8;
        nbytes = rb * h;
        // cut long or some random blits short; stray bytes past the end are ignored
        if (nbytes > 48 || $urandom_range(9) == 0) nbytes = $urandom_range(0, rb * 3);
        repeat (nbytes) send_data($urandom_range(255));
        base = y * new_stride + x / 8;
        span = ((h > 4) ? 4 : h) * new_stride + rb;
        repeat ($urandom_range(1, 3)) send_read((base + $urandom_range(0, span)) % FRAME_BYTES);
      end else begin
        case ($urandom_range(3))
          0: send_read($urandom_range(FRAME_BYTES - 1));
          1: send_data($urandom_range(255));
          2: send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom), 8'($urandom), 11'($urandom));
          default: send_begin($urandom_range(255), $urandom_range(255), $urandom_range(255),
                              $urandom_range(255), 1'($urandom));
        endcase
      end
    end
  endtask

  task automatic test_back_to_back();
    no_gaps <= 1'b1;
    test_random_blits(6'($urandom_range(1, 32)), 300);
    no_gaps <= 1'b0;
  endtask

  task automatic test_backpressure();
    drain();
    no_gaps  <= 1'b1;
    hold_req <= ~hold_req;
    send_begin(4, 2, 16, 2, 1'b0);
    repeat (4) send_data($urandom_range(255));
    repeat (60) send_read($urandom_range(FRAME_BYTES - 1));
    no_gaps <= 1'b0;
  endtask

  // result side: random stalls plus one long hold on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_ready_i <= 1'b0;
      hold_left   <= HOLD_CYC;
      hold_ack    <= hold_req;
    end else begin
      out_ready_i <= no_gaps || ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fb_expect_q.size() == 0) begin
        report_mismatch($sformatf("read_data %02h with no read pending", read_data_o));
      end else begin
        rd_exp = fb_expect_q.pop_front();
        if (read_data_o !== rd_exp.data)
          report_mismatch($sformatf("addr %0d read_data %02h, want %02h",
                                    rd_exp.addr, read_data_o, rd_exp.data));
      end
    end
  end

  // end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_mono_bitmap_blit_unit: errors");
        $finish;
      end
    end
  end

  initial begin
    foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_after_reset();
    test_directed_blits();
    test_random_blits(6'd1, 350);
    test_random_blits(6'd32, 350);
    test_back_to_back();
    test_backpressure();
    test_random_blits(6'($urandom_range(1, 32)), 350);
    test_random_blits(STRIDE_RESET, 450);
    drain();
    if (error_count == 0) begin
      $display("tb_mono_bitmap_blit_unit: clean");
    end else begin
      $display("tb_mono_bitmap_blit_unit: errors");
    end
    $finish;
  end

endmodule
